// ===== rtl/ufp_pkg.sv =====
// Shared types and constants of the UART command frame parser.
package ufp_pkg;

  localparam int unsigned BUFFER_BYTES_DEFAULT = 64;
  localparam logic [7:0]  HEADER_RESET         = 8'hAA;
  localparam logic [7:0]  TEXT_MARK            = 8'h24;

  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_IDLE    = 2'd1;
  localparam logic [1:0] OP_CONSUME = 2'd2;

  localparam logic [7:0] CMD_RUN        = 8'h01;
  localparam logic [7:0] CMD_HALT       = 8'h02;
  localparam logic [7:0] CMD_SPEED      = 8'h03;
  localparam logic [7:0] CMD_QUERY      = 8'h04;
  localparam logic [7:0] CMD_TOGGLE_DIR = 8'h05;
  localparam logic [7:0] CMD_HELP       = 8'h06;

  localparam logic [2:0] COMMAND_NONE      = 3'd0;
  localparam logic [2:0] COMMAND_SET_SPEED = 3'd3;
  localparam logic [2:0] COMMAND_LAST      = 3'd5;

  typedef enum logic [2:0] {
    ST_POSTED   = 3'd0,
    ST_CHECKSUM = 3'd1,
    ST_HELP     = 3'd2,
    ST_UNKNOWN  = 3'd3,
    ST_REJECTED = 3'd4,
    ST_BUSY     = 3'd5
  } status_t;

  // Hex pair tracker state.
  typedef struct packed {
    logic       held_valid;
    logic [7:0] held_char;
    logic [7:0] acc;
  } hex_state_t;

  // Everything the frame judge looks at when a frame ends.
  typedef struct packed {
    logic       count_ge2;
    logic       count_ge3;
    logic       count_ge5;
    logic [7:0] first_byte;
    logic [7:0] command_byte;
    logic [7:0] param_high;
    logic [7:0] param_low;
    logic [7:0] running_xor;
    logic [7:0] hex_xor;
    logic       pending;
    logic [7:0] header;
  } judge_in_t;

  typedef struct packed {
    status_t     status;
    logic [2:0]  command;
    logic [15:0] param;
    logic [7:0]  checksum;
    logic        post;
  } judge_out_t;

endpackage

// ===== rtl/ufp_hex_tracker.sv =====
// Next-state logic of the hex pair tracker for text frames.
module ufp_hex_tracker (
  input  ufp_pkg::hex_state_t cur,
  input  logic [7:0]          char_in,
  output ufp_pkg::hex_state_t nxt
);

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
  endfunction

  // Bit 4 set means the character is not a hex digit.
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [4:0] n;
    n = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) n = {1'b0, c[3:0]};
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      n = {1'b0, c[3:0] + 4'd9};
    return n;
  endfunction

  logic [4:0] hi;
  logic [4:0] lo;
  logic       space;

  assign hi    = nibble_of(cur.held_char);
  assign lo    = nibble_of(char_in);
  assign space = is_space(char_in);

  always_comb begin
    nxt = cur;
    if (!cur.held_valid) begin
      if (!space) begin
        nxt.held_char  = char_in;
        nxt.held_valid = 1'b1;
      end
    end else if (!hi[4] && !lo[4]) begin
      nxt.acc        = cur.acc ^ {hi[3:0], lo[3:0]};
      nxt.held_valid = 1'b0;
      nxt.held_char  = 8'h00;
    end else if (space) begin
      nxt.held_valid = 1'b0;
      nxt.held_char  = 8'h00;
    end else begin
      nxt.held_char = char_in;
    end
  end

endmodule

// ===== rtl/ufp_frame_judge.sv =====
// Decision logic applied when the line goes idle at the end of a frame.
module ufp_frame_judge (
  input  ufp_pkg::judge_in_t  jin,
  output ufp_pkg::judge_out_t jout
);

  always_comb begin
    jout.status   = ufp_pkg::ST_REJECTED;
    jout.command  = ufp_pkg::COMMAND_NONE;
    jout.param    = 16'h0000;
    jout.checksum = 8'h00;
    jout.post     = 1'b0;
    priority if (jin.pending) begin
      jout.status = ufp_pkg::ST_BUSY;
    end else if (jin.count_ge2 && jin.first_byte == ufp_pkg::TEXT_MARK) begin
      jout.status   = ufp_pkg::ST_CHECKSUM;
      jout.checksum = jin.hex_xor;
    end else if (!jin.count_ge3 || jin.running_xor != 8'h00 ||
                 jin.first_byte != jin.header) begin
      jout.status = ufp_pkg::ST_REJECTED;
    end else begin
      unique case (jin.command_byte)
        ufp_pkg::CMD_RUN, ufp_pkg::CMD_HALT, ufp_pkg::CMD_QUERY,
        ufp_pkg::CMD_TOGGLE_DIR: begin
          jout.status  = ufp_pkg::ST_POSTED;
          jout.command = jin.command_byte[2:0];
          jout.post    = 1'b1;
        end
        ufp_pkg::CMD_SPEED: begin
          if (jin.count_ge5) begin
            jout.status  = ufp_pkg::ST_POSTED;
            jout.command = ufp_pkg::COMMAND_SET_SPEED;
            jout.param   = {jin.param_high, jin.param_low};
            jout.post    = 1'b1;
          end
        end
        ufp_pkg::CMD_HELP: begin
          jout.status = ufp_pkg::ST_HELP;
        end
        default: begin
          jout.status = ufp_pkg::ST_UNKNOWN;
        end
      endcase
    end
  end

endmodule

// ===== rtl/uart_command_frame_parser_unit.sv =====
// Top level of the UART command frame parser.
//
// The input channel (in_valid, in_stall, opcode, data_byte) carries one UART
// event per beat: a received byte, a line-idle marker that closes the frame,
// or a consume event from the host that frees the command slot. Opcode 3 is
// accepted and ignored.
// The output channel (out_valid, out_stall, status, command, param,
// checksum) carries at most one result beat per idle marker that closes a
// frame holding data. Bytes, consume events and empty idles give no beat.
// The header register is written through cfg_we and cfg_wdata; the user must
// write it only while the block is idle (not enforced); it resets to 0xAA.
// An accepted beat lands in an input register. When that beat moves on, the
// frame state is updated and any result is loaded into the output register.
// One beat is taken every cycle unless a stalled result holds the pipeline.
// When the receiver stalls a waiting result, the input register stops, and
// in_stall rises once that register also holds a beat, so nothing is lost.
// Synchronous reset clears the frame, the pending command flag and both
// pipeline valid bits.
module uart_command_frame_parser_unit #(
  parameter int unsigned BUFFER_BYTES = ufp_pkg::BUFFER_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [2:0]  command,
  output logic [15:0] param,
  output logic [7:0]  checksum,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  localparam int unsigned CW = $clog2(BUFFER_BYTES + 1);

  // Input register.
  logic       s1_valid;
  logic [1:0] s1_op;
  logic [7:0] s1_data;

  // Frame state.
  logic [CW-1:0]       byte_count, byte_count_next;
  logic [7:0]          running_xor, running_xor_next;
  logic [7:0]          first_byte, first_byte_next;
  logic [7:0]          command_byte, command_byte_next;
  logic [7:0]          param_high, param_high_next;
  logic [7:0]          param_low, param_low_next;
  ufp_pkg::hex_state_t hex_state, hex_state_next, hex_tracked;
  logic                command_pending, command_pending_next;
  logic [7:0]          header_byte;

  ufp_pkg::judge_in_t  jin;
  ufp_pkg::judge_out_t jout;

  logic advance;
  logic produce;
  logic s1_take;

  // The pipeline moves whenever the output register is empty or being taken.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign s1_take  = s1_valid && advance;

  // The input register refills whenever it is empty or its beat moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op   <= opcode;
      s1_data <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= ufp_pkg::HEADER_RESET;
    end else if (cfg_we) begin
      header_byte <= cfg_wdata;
    end
  end

  ufp_hex_tracker u_hex (
    .cur     (hex_state),
    .char_in (s1_data),
    .nxt     (hex_tracked)
  );

  always_comb begin
    jin.count_ge2    = byte_count >= CW'(2);
    jin.count_ge3    = byte_count >= CW'(3);
    jin.count_ge5    = byte_count >= CW'(5);
    jin.first_byte   = first_byte;
    jin.command_byte = command_byte;
    jin.param_high   = param_high;
    jin.param_low    = param_low;
    jin.running_xor  = running_xor;
    jin.hex_xor      = hex_state.acc;
    jin.pending      = command_pending;
    jin.header       = header_byte;
  end

  ufp_frame_judge u_judge (
    .jin  (jin),
    .jout (jout)
  );

  always_comb begin
    byte_count_next      = byte_count;
    running_xor_next     = running_xor;
    first_byte_next      = first_byte;
    command_byte_next    = command_byte;
    param_high_next      = param_high;
    param_low_next       = param_low;
    hex_state_next       = hex_state;
    command_pending_next = command_pending;
    produce              = 1'b0;
    if (s1_take) begin
      unique case (s1_op)
        ufp_pkg::OP_BYTE: begin
          if (byte_count == CW'(BUFFER_BYTES)) begin
            // Overflow: the byte is dropped and the frame starts again empty.
            byte_count_next   = '0;
            running_xor_next  = 8'h00;
            first_byte_next   = 8'h00;
            command_byte_next = 8'h00;
            param_high_next   = 8'h00;
            param_low_next    = 8'h00;
            hex_state_next    = '0;
          end else begin
            if (byte_count == CW'(0)) first_byte_next = s1_data;
            if (byte_count == CW'(1)) command_byte_next = s1_data;
            if (byte_count == CW'(2)) param_high_next = s1_data;
            if (byte_count == CW'(3)) param_low_next = s1_data;
            // Hex pairs are scanned from the second byte on.
            if (byte_count != CW'(0)) hex_state_next = hex_tracked;
            running_xor_next = running_xor ^ s1_data;
            byte_count_next  = byte_count + CW'(1);
          end
        end
        ufp_pkg::OP_IDLE: begin
          if (byte_count != CW'(0)) begin
            produce           = 1'b1;
            byte_count_next   = '0;
            running_xor_next  = 8'h00;
            first_byte_next   = 8'h00;
            command_byte_next = 8'h00;
            param_high_next   = 8'h00;
            param_low_next    = 8'h00;
            hex_state_next    = '0;
            if (jout.post) command_pending_next = 1'b1;
          end
        end
        ufp_pkg::OP_CONSUME: begin
          command_pending_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      running_xor     <= 8'h00;
      first_byte      <= 8'h00;
      command_byte    <= 8'h00;
      param_high      <= 8'h00;
      param_low       <= 8'h00;
      hex_state       <= '0;
      command_pending <= 1'b0;
    end else begin
      byte_count      <= byte_count_next;
      running_xor     <= running_xor_next;
      first_byte      <= first_byte_next;
      command_byte    <= command_byte_next;
      param_high      <= param_high_next;
      param_low       <= param_low_next;
      hex_state       <= hex_state_next;
      command_pending <= command_pending_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= produce;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      status   <= jout.status;
      command  <= jout.command;
      param    <= jout.param;
      checksum <= jout.checksum;
    end
  end

endmodule

// ===== rtl/ufp_checker.sv =====
// Port-level assertions for the UART command frame parser, bound to the top.
module ufp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic [2:0]  command,
  input logic [15:0] param,
  input logic [7:0]  checksum
);

  // A stalled result beat stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat withdrawn while stalled");

  // Only a posted command carries a command code.
  a_cmd_only_posted: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ufp_pkg::ST_POSTED |-> command == ufp_pkg::COMMAND_NONE)
    else $error("command code on a beat that posts nothing");

  // A posted command is one of the five real commands.
  a_cmd_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ufp_pkg::ST_POSTED |->
      command != ufp_pkg::COMMAND_NONE && command <= ufp_pkg::COMMAND_LAST)
    else $error("posted beat with a bad command code");

  // Speed value only with set speed.
  a_param: assert property (@(posedge clk) disable iff (rst)
    out_valid && command != ufp_pkg::COMMAND_SET_SPEED |-> param == 16'h0000)
    else $error("speed value on a beat that is not set speed");

  // Checksum only on a checksum reply.
  a_checksum: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ufp_pkg::ST_CHECKSUM |-> checksum == 8'h00)
    else $error("checksum on a beat that is not a checksum reply");

endmodule

bind uart_command_frame_parser_unit ufp_checker u_ufp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .command   (command),
  .param     (param),
  .checksum  (checksum)
);
